// ===== src/dplc_pkg.sv =====
// Shared types, constants and register indexes of the duplex pump lead/lag controller.
package dplc_pkg;

  localparam int TIME_W = 32;
  localparam int RT_W = 32;
  localparam int LEVEL_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_CNT_W = $clog2(TIME_W);

  localparam logic [CFG_IDX_W-1:0] REG_TIME_UNIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL = 3'd4;

  localparam logic [TIME_W-1:0] TIME_UNIT_RESET = 32'd60000;
  localparam logic [RT_W-1:0] LAG_DELAY_RESET = 32'd5;
  localparam logic [RT_W-1:0] SWAP_THRESHOLD_RESET = 32'd60;
  localparam logic [LEVEL_W-1:0] START_LEVEL_RESET = 4'd5;
  localparam logic [LEVEL_W-1:0] STOP_LEVEL_RESET = 4'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEAD_DIV,
    S_ACC_LOAD,
    S_ACC_DIV,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic acc_load;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic lead_running;
    logic acc_due;
    logic div_last;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// ===== src/dplc_div.sv =====
// Serial restoring divider, one quotient bit per step.
module dplc_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic                          step,
  input  logic [dplc_pkg::TIME_W-1:0]   dividend,
  input  logic [dplc_pkg::TIME_W-1:0]   divisor,
  output logic [dplc_pkg::TIME_W-1:0]   quot,
  output logic                          last
);

  logic [dplc_pkg::TIME_W-1:0]    rem;
  logic [dplc_pkg::DIV_CNT_W-1:0] count;
  logic [dplc_pkg::TIME_W:0]      rem_sh;
  logic [dplc_pkg::TIME_W:0]      diff;

  assign rem_sh = {rem, quot[dplc_pkg::TIME_W-1]};
  assign diff = rem_sh - {1'b0, divisor};
  assign last = (count == dplc_pkg::DIV_CNT_W'(dplc_pkg::TIME_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= '0;
    end else if (step) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quot <= dividend;
    end else if (step) begin
      if (!diff[dplc_pkg::TIME_W]) begin
        rem <= diff[dplc_pkg::TIME_W-1:0];
        quot <= {quot[dplc_pkg::TIME_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[dplc_pkg::TIME_W-1:0];
        quot <= {quot[dplc_pkg::TIME_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/dplc_datapath.sv =====
// Datapath: configuration, pump state, divider feed, commit logic and result register.
module dplc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dplc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dplc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [dplc_pkg::LEVEL_W-1:0]    alarm_level,
  input  logic [dplc_pkg::TIME_W-1:0]     now_ms,
  input  logic                            out_ready,
  input  dplc_pkg::ctrl_cmd_t             cmd,
  output dplc_pkg::ctrl_sts_t             sts,
  output logic                            out_valid,
  output logic                            pump_one_on,
  output logic                            pump_two_on,
  output logic [dplc_pkg::RT_W-1:0]       pump_one_runtime,
  output logic [dplc_pkg::RT_W-1:0]       pump_two_runtime,
  output logic                            lead_is_pump_two
);

  logic [dplc_pkg::TIME_W-1:0]  time_unit_ms;
  logic [dplc_pkg::RT_W-1:0]    lag_delay_units;
  logic [dplc_pkg::RT_W-1:0]    swap_threshold_units;
  logic [dplc_pkg::LEVEL_W-1:0] start_level;
  logic [dplc_pkg::LEVEL_W-1:0] stop_level;

  logic [dplc_pkg::RT_W-1:0]    runtime_one;
  logic [dplc_pkg::RT_W-1:0]    runtime_two;
  logic [dplc_pkg::TIME_W-1:0]  last_account_ms;
  logic [dplc_pkg::TIME_W-1:0]  lead_start_ms;
  logic                         lag_start_pending;
  logic                         lead_running;
  logic                         lag_running;
  logic                         lead_on_two;

  logic [dplc_pkg::LEVEL_W-1:0] level_q;
  logic [dplc_pkg::TIME_W-1:0]  now_q;
  logic                         lag_due;
  logic                         acc_due_q;

  logic [dplc_pkg::TIME_W-1:0]  divisor;
  logic [dplc_pkg::TIME_W-1:0]  dividend;
  logic [dplc_pkg::TIME_W-1:0]  quot;
  logic                         div_last;
  logic [dplc_pkg::TIME_W-1:0]  elapsed_acc;

  logic                         start_hit;
  logic                         stop_hit;
  logic                         pend;
  logic                         lead_next;
  logic                         lag_next;
  logic                         pend_next;
  logic [dplc_pkg::TIME_W-1:0]  lead_start_next;
  logic                         one_gt;
  logic [dplc_pkg::RT_W-1:0]    gap;
  logic                         lead_on_two_next;
  logic                         drive_one;
  logic                         drive_two;
  logic [dplc_pkg::RT_W:0]      sum_one;
  logic [dplc_pkg::RT_W:0]      sum_two;
  logic [dplc_pkg::RT_W-1:0]    runtime_one_next;
  logic [dplc_pkg::RT_W-1:0]    runtime_two_next;

  assign divisor = (time_unit_ms == '0) ? dplc_pkg::TIME_W'(1) : time_unit_ms;
  assign elapsed_acc = now_q - last_account_ms;
  assign dividend = cmd.accept ? (now_ms - lead_start_ms) : elapsed_acc;

  dplc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .load     (cmd.accept | cmd.acc_load),
    .step     (cmd.div_step),
    .dividend (dividend),
    .divisor  (divisor),
    .quot     (quot),
    .last     (div_last)
  );

  assign sts.lead_running = lead_running;
  assign sts.acc_due = (elapsed_acc > time_unit_ms);
  assign sts.div_last = div_last;
  assign sts.out_busy = out_valid & ~out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_unit_ms <= dplc_pkg::TIME_UNIT_RESET;
      lag_delay_units <= dplc_pkg::LAG_DELAY_RESET;
      swap_threshold_units <= dplc_pkg::SWAP_THRESHOLD_RESET;
      start_level <= dplc_pkg::START_LEVEL_RESET;
      stop_level <= dplc_pkg::STOP_LEVEL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        dplc_pkg::REG_TIME_UNIT: time_unit_ms <= cfg_data[dplc_pkg::TIME_W-1:0];
        dplc_pkg::REG_LAG_DELAY: lag_delay_units <= cfg_data[dplc_pkg::RT_W-1:0];
        dplc_pkg::REG_SWAP_THRESHOLD: swap_threshold_units <= cfg_data[dplc_pkg::RT_W-1:0];
        dplc_pkg::REG_START_LEVEL: start_level <= cfg_data[dplc_pkg::LEVEL_W-1:0];
        dplc_pkg::REG_STOP_LEVEL: stop_level <= cfg_data[dplc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      level_q <= alarm_level;
      now_q <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_due <= 1'b0;
      acc_due_q <= 1'b0;
    end else if (cmd.accept) begin
      lag_due <= 1'b0;
      acc_due_q <= 1'b0;
    end else if (cmd.acc_load) begin
      lag_due <= lead_running & (quot > lag_delay_units);
      acc_due_q <= sts.acc_due;
    end
  end

  always_comb begin
    start_hit = (level_q >= start_level);
    stop_hit = (level_q <= stop_level);
    pend = lag_start_pending | lag_due;
    lead_next = lead_running;
    lag_next = lag_running;
    pend_next = pend;
    lead_start_next = lead_start_ms;
    if (start_hit && !lead_running) begin
      lead_next = 1'b1;
      lead_start_next = now_q;
      pend_next = 1'b0;
    end else if (start_hit && pend) begin
      lag_next = 1'b1;
      pend_next = 1'b0;
    end else if (stop_hit) begin
      lead_next = 1'b0;
      lag_next = 1'b0;
      pend_next = 1'b0;
    end

    one_gt = (runtime_one > runtime_two);
    gap = one_gt ? (runtime_one - runtime_two) : (runtime_two - runtime_one);
    lead_on_two_next = (gap > swap_threshold_units) ? (runtime_two < runtime_one)
                                                    : lead_on_two;
    drive_one = lead_on_two_next ? lag_next : lead_next;
    drive_two = lead_on_two_next ? lead_next : lag_next;

    sum_one = {1'b0, runtime_one} + {1'b0, quot};
    sum_two = {1'b0, runtime_two} + {1'b0, quot};
    runtime_one_next = runtime_one;
    runtime_two_next = runtime_two;
    if (acc_due_q && drive_one) begin
      runtime_one_next = (sum_one >= {1'b0, {dplc_pkg::RT_W{1'b1}}}) ?
                         {dplc_pkg::RT_W{1'b1}} : sum_one[dplc_pkg::RT_W-1:0];
    end
    if (acc_due_q && drive_two) begin
      runtime_two_next = (sum_two >= {1'b0, {dplc_pkg::RT_W{1'b1}}}) ?
                         {dplc_pkg::RT_W{1'b1}} : sum_two[dplc_pkg::RT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      runtime_one <= '0;
      runtime_two <= '0;
      last_account_ms <= '0;
      lead_start_ms <= '0;
      lag_start_pending <= 1'b0;
      lead_running <= 1'b0;
      lag_running <= 1'b0;
      lead_on_two <= 1'b0;
    end else if (cmd.commit) begin
      runtime_one <= runtime_one_next;
      runtime_two <= runtime_two_next;
      if (acc_due_q) begin
        last_account_ms <= now_q;
      end
      lead_start_ms <= lead_start_next;
      lag_start_pending <= pend_next;
      lead_running <= lead_next;
      lag_running <= lag_next;
      lead_on_two <= lead_on_two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pump_one_on <= drive_one;
      pump_two_on <= drive_two;
      pump_one_runtime <= runtime_one_next;
      pump_two_runtime <= runtime_two_next;
      lead_is_pump_two <= lead_on_two_next;
    end
  end

endmodule

// ===== src/dplc_ctrl.sv =====
// Controller state machine sequencing accept, up to two divisions and commit.
module dplc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dplc_pkg::ctrl_sts_t sts,
  output dplc_pkg::ctrl_cmd_t cmd
);

  dplc_pkg::state_t state;
  dplc_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dplc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      dplc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = sts.lead_running ? dplc_pkg::S_LEAD_DIV : dplc_pkg::S_ACC_LOAD;
        end
      end
      dplc_pkg::S_LEAD_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = dplc_pkg::S_ACC_LOAD;
        end
      end
      dplc_pkg::S_ACC_LOAD: begin
        cmd.acc_load = 1'b1;
        state_next = sts.acc_due ? dplc_pkg::S_ACC_DIV : dplc_pkg::S_COMMIT;
      end
      dplc_pkg::S_ACC_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = dplc_pkg::S_COMMIT;
        end
      end
      dplc_pkg::S_COMMIT: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_next = dplc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dplc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/duplex_pump_lead_lag_controller_core.sv =====
// Top level of the duplex pump lead/lag controller.
//
// Input channel (in_valid/in_ready) transfers one control step: alarm_level
// and the millisecond timestamp now_ms. Output channel (out_valid/out_ready)
// transfers one result per step: both pump drives, both runtimes and the
// lead assignment. Registers are written through cfg_we/cfg_index/cfg_data by
// the user only while the block is idle, not enforced by it; index 0 unit ms,
// 1 lag delay, 2 swap threshold, 3 start level, 4 stop level; others are ignored.
// A step runs from transfer in to the next in_ready through accept, the
// divisions and commit: one 32-step serial divider computes the lead run
// time in units (only while the lead pump runs) and then, after a reload,
// the elapsed accounting units (only when more than one unit has passed),
// one quotient bit per cycle.
// The result sits in an output register; the next step is taken while it
// waits. If the receiver stalls, the following step holds before commit
// until the pending result is transferred.
// Reset (rst, synchronous) restores register defaults, clears runtimes,
// timestamps and pump state, and empties the output register.
module duplex_pump_lead_lag_controller_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dplc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dplc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dplc_pkg::LEVEL_W-1:0]    alarm_level,
  input  logic [dplc_pkg::TIME_W-1:0]     now_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            pump_one_on,
  output logic                            pump_two_on,
  output logic [dplc_pkg::RT_W-1:0]       pump_one_runtime,
  output logic [dplc_pkg::RT_W-1:0]       pump_two_runtime,
  output logic                            lead_is_pump_two
);

  dplc_pkg::ctrl_cmd_t cmd;
  dplc_pkg::ctrl_sts_t sts;

  dplc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dplc_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .alarm_level      (alarm_level),
    .now_ms           (now_ms),
    .out_ready        (out_ready),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .pump_one_on      (pump_one_on),
    .pump_two_on      (pump_two_on),
    .pump_one_runtime (pump_one_runtime),
    .pump_two_runtime (pump_two_runtime),
    .lead_is_pump_two (lead_is_pump_two)
  );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the duplex pump lead/lag controller core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic [dplc_pkg::LEVEL_W-1:0] level;
    logic [dplc_pkg::TIME_W-1:0]  now;
  } step_t;

  typedef struct packed {
    logic                      one_on;
    logic                      two_on;
    logic [dplc_pkg::RT_W-1:0] one_rt;
    logic [dplc_pkg::RT_W-1:0] two_rt;
    logic                      lead_two;
  } pump_status_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [dplc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [dplc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [dplc_pkg::LEVEL_W-1:0]    alarm_level = '0;
  logic [dplc_pkg::TIME_W-1:0]     now_ms = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            pump_one_on;
  logic                            pump_two_on;
  logic [dplc_pkg::RT_W-1:0]       pump_one_runtime;
  logic [dplc_pkg::RT_W-1:0]       pump_two_runtime;
  logic                            lead_is_pump_two;

  duplex_pump_lead_lag_controller_core dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .alarm_level      (alarm_level),
    .now_ms           (now_ms),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pump_one_on      (pump_one_on),
    .pump_two_on      (pump_two_on),
    .pump_one_runtime (pump_one_runtime),
    .pump_two_runtime (pump_two_runtime),
    .lead_is_pump_two (lead_is_pump_two)
  );

  // controller mirror: configuration and state
  logic [dplc_pkg::TIME_W-1:0]  m_unit = dplc_pkg::TIME_UNIT_RESET;
  logic [dplc_pkg::RT_W-1:0]    m_lag_delay = dplc_pkg::LAG_DELAY_RESET;
  logic [dplc_pkg::RT_W-1:0]    m_swap = dplc_pkg::SWAP_THRESHOLD_RESET;
  logic [dplc_pkg::LEVEL_W-1:0] m_start = dplc_pkg::START_LEVEL_RESET;
  logic [dplc_pkg::LEVEL_W-1:0] m_stop = dplc_pkg::STOP_LEVEL_RESET;
  logic [dplc_pkg::RT_W-1:0]    m_rt_one = '0;
  logic [dplc_pkg::RT_W-1:0]    m_rt_two = '0;
  logic [dplc_pkg::TIME_W-1:0]  m_last_acct = '0;
  logic [dplc_pkg::TIME_W-1:0]  m_lead_start = '0;
  logic                         m_lag_pend = 1'b0;
  logic                         m_lead_run = 1'b0;
  logic                         m_lag_run = 1'b0;
  logic                         m_lead_two = 1'b0;
  logic                         m_drv_one = 1'b0;
  logic                         m_drv_two = 1'b0;

  step_t        step_q[$];
  pump_status_t status_q[$];
  int           pushed_cnt = 0;
  int           issued_cnt = 0;
  int           sent_cnt = 0;
  int           errors = 0;
  int           cycle_cnt = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           ready_left = 0;
  int           ready_mode = 0;
  logic [dplc_pkg::TIME_W-1:0] gen_now = '0;
  logic                        gen_pumping = 1'b0;
  int                          gen_run = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [dplc_pkg::RT_W-1:0] sat_add(
      input logic [dplc_pkg::RT_W-1:0] acc,
      input logic [dplc_pkg::RT_W-1:0] inc);
    logic [dplc_pkg::RT_W:0] sum;
    sum = {1'b0, acc} + {1'b0, inc};
    return sum[dplc_pkg::RT_W] ? '1 : sum[dplc_pkg::RT_W-1:0];
  endfunction

  function automatic void advance_pumps(input logic [dplc_pkg::LEVEL_W-1:0] level,
                                        input logic [dplc_pkg::TIME_W-1:0] now);
    logic [dplc_pkg::TIME_W-1:0] div;
    logic [dplc_pkg::TIME_W-1:0] span;
    logic [dplc_pkg::RT_W-1:0]   units;
    logic [dplc_pkg::RT_W-1:0]   gap;
    pump_status_t                s;
    div = (m_unit == '0) ? dplc_pkg::TIME_W'(1) : m_unit;
    span = now - m_lead_start;
    if (m_lead_run && (span / div) > m_lag_delay) m_lag_pend = 1'b1;
    if (level >= m_start && !m_lead_run) begin
      m_lead_run = 1'b1;
      m_lead_start = now;
      m_lag_pend = 1'b0;
    end else if (level >= m_start && m_lag_pend) begin
      m_lag_run = 1'b1;
      m_lag_pend = 1'b0;
    end else if (level <= m_stop) begin
      m_lead_run = 1'b0;
      m_lag_run = 1'b0;
      m_lag_pend = 1'b0;
    end
    gap = (m_rt_one > m_rt_two) ? m_rt_one - m_rt_two : m_rt_two - m_rt_one;
    if (gap > m_swap) m_lead_two = (m_rt_two < m_rt_one);
    if (m_lead_two) begin
      m_drv_one = m_lag_run;
      m_drv_two = m_lead_run;
    end else begin
      m_drv_one = m_lead_run;
      m_drv_two = m_lag_run;
    end
    span = now - m_last_acct;
    if (span > m_unit) begin
      units = span / div;
      m_last_acct = now;
      if (m_drv_one) m_rt_one = sat_add(m_rt_one, units);
      if (m_drv_two) m_rt_two = sat_add(m_rt_two, units);
    end
    s.one_on = m_drv_one;
    s.two_on = m_drv_two;
    s.one_rt = m_rt_one;
    s.two_rt = m_rt_two;
    s.lead_two = m_lead_two;
    status_q.push_back(s);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void queue_step(input logic [dplc_pkg::LEVEL_W-1:0] level,
                                     input logic [dplc_pkg::TIME_W-1:0] now);
    step_t st;
    st.level = level;
    st.now = now;
    step_q.push_back(st);
    pushed_cnt++;
    gen_now = now;
  endfunction

  function automatic void queue_random_steps(input int n);
    logic [dplc_pkg::TIME_W-1:0]  u;
    logic [dplc_pkg::TIME_W-1:0]  delta;
    logic [63:0]                  prod;
    logic [dplc_pkg::LEVEL_W-1:0] level;
    u = (m_unit == '0) ? dplc_pkg::TIME_W'(1) : m_unit;
    for (int i = 0; i < n; i++) begin
      if (gen_run == 0) begin
        gen_pumping = ~gen_pumping;
        gen_run = $urandom_range(3, 12);
      end
      gen_run--;
      if ($urandom_range(0, 99) < 15) begin
        level = dplc_pkg::LEVEL_W'($urandom_range(0, 15));
      end else if (gen_pumping) begin
        level = dplc_pkg::LEVEL_W'($urandom_range(m_start, 15));
      end else begin
        level = dplc_pkg::LEVEL_W'($urandom_range(0, m_stop));
      end
      case ($urandom_range(0, 9))
        0: delta = '0;
        1, 2: delta = $urandom_range(0, u - 1);
        3, 4, 5: begin
          prod = 64'(u) * 64'($urandom_range(0, 8));
          delta = prod[dplc_pkg::TIME_W-1:0] + $urandom_range(0, 3);
        end
        6: delta = u;
        7: delta = u + 1;
        8: delta = $urandom;
        default: delta = $urandom_range(0, 50);
      endcase
      queue_step(level, gen_now + delta);
    end
  endfunction

  task automatic write_reg(input logic [dplc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    case (idx)
      dplc_pkg::REG_TIME_UNIT: m_unit = val;
      dplc_pkg::REG_LAG_DELAY: m_lag_delay = val;
      dplc_pkg::REG_SWAP_THRESHOLD: m_swap = val;
      dplc_pkg::REG_START_LEVEL: m_start = val[dplc_pkg::LEVEL_W-1:0];
      dplc_pkg::REG_STOP_LEVEL: m_stop = val[dplc_pkg::LEVEL_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] unit, input logic [31:0] lag,
                          input logic [31:0] swap, input logic [31:0] start,
                          input logic [31:0] stop);
    write_reg(dplc_pkg::REG_TIME_UNIT, unit);
    write_reg(dplc_pkg::REG_LAG_DELAY, lag);
    write_reg(dplc_pkg::REG_SWAP_THRESHOLD, swap);
    write_reg(dplc_pkg::REG_START_LEVEL, start);
    write_reg(dplc_pkg::REG_STOP_LEVEL, stop);
  endtask

  task automatic drain_results();
    while (sent_cnt != pushed_cnt || status_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(negedge clk) begin : drive_steps
    step_t nx;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sent_cnt == issued_cnt) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (step_q.size() > 0) begin
        nx = step_q.pop_front();
        in_valid <= 1'b1;
        alarm_level <= nx.level;
        now_ms <= nx.now;
        issued_cnt <= issued_cnt + 1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches at random among four modes
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(16, 400);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 31) == 0);
      default: out_ready <= cycle_cnt[2];
    endcase
  end

  always @(posedge clk) begin : watch_ports
    pump_status_t exp_s;
    if (!rst) begin
      if (in_valid && in_ready) begin
        advance_pumps(alarm_level, now_ms);
        sent_cnt++;
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          errors++;
          $display("%0t result transfer with none expected: actual %0h %0h %0h %0h %0h",
                   $time, pump_one_on, pump_two_on, pump_one_runtime,
                   pump_two_runtime, lead_is_pump_two);
        end else begin
          exp_s = status_q.pop_front();
          check_field("pump_one_on", 32'(exp_s.one_on), 32'(pump_one_on));
          check_field("pump_two_on", 32'(exp_s.two_on), 32'(pump_two_on));
          check_field("pump_one_runtime", exp_s.one_rt, pump_one_runtime);
          check_field("pump_two_runtime", exp_s.two_rt, pump_two_runtime);
          check_field("lead_is_pump_two", 32'(exp_s.lead_two), 32'(lead_is_pump_two));
        end
      end
    end
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    logic [31:0] unit;
    logic [31:0] lag;
    logic [31:0] swap;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_regs(10, 2, 3, 5, 3);
    queue_step(4'd0, 32'h0000_0000);
    queue_step(4'd15, 32'h0000_0005);
    queue_step(4'd15, 32'h0000_0014);
    queue_step(4'd15, 32'h0000_0028);
    queue_step(4'd4, 32'h0000_003c);
    queue_step(4'd3, 32'h0000_0050);
    queue_step(4'd0, 32'h0000_005f);
    queue_step(4'd5, 32'h0000_0064);
    queue_step(4'd15, 32'hffff_fff0);
    queue_step(4'd15, 32'h0000_0020);
    queue_step(4'd15, 32'h0000_0040);
    queue_step(4'd2, 32'h0000_0050);
    queue_step(4'd15, 32'hffff_ffff);
    queue_step(4'd15, 32'h0000_0000);
    queue_step(4'd8, 32'h7fff_ffff);
    queue_step(4'd3, 32'h8000_0000);
    queue_step(4'd15, 32'h8000_0000);
    queue_step(4'd15, 32'h8000_0005);
    queue_step(4'd15, 32'h8000_0040);
    queue_step(4'd0, 32'h8000_0100);
    drain_results();

    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: set_regs(1, 0, 0, 0, 0);
        1: set_regs(0, 3, 5, 8, 2);
        2: set_regs('1, '1, '1, 15, 15);
        3: set_regs(1000, 2, 10, 7, 7);
        default: begin
          case ($urandom_range(0, 4))
            0: unit = 1;
            1: unit = $urandom_range(1, 100);
            2: unit = $urandom_range(100, 100000);
            3: unit = dplc_pkg::TIME_UNIT_RESET;
            default: unit = $urandom;
          endcase
          lag = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 8);
          swap = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 200);
          set_regs(unit, lag, swap,
                   {28'($urandom_range(0, 32'h0fff_ffff)), 4'($urandom_range(0, 15))},
                   {28'($urandom_range(0, 32'h0fff_ffff)), 4'($urandom_range(0, 15))});
        end
      endcase
      if (ph == 3) begin
        write_reg(dplc_pkg::REG_STOP_LEVEL + 3'd1, $urandom);
        write_reg(dplc_pkg::REG_STOP_LEVEL + 3'd2, $urandom);
        write_reg(dplc_pkg::REG_STOP_LEVEL + 3'd3, $urandom);
      end
      queue_random_steps((ph == 2) ? 60 : 190);
      drain_results();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
